[rtl/keyboard_event_buffer_controller_unit_assert.svh]
// Assertion macros for the keyboard event buffer controller
`ifndef KEYBOARD_EVENT_BUFFER_CONTROLLER_UNIT_ASSERT_SVH
`define KEYBOARD_EVENT_BUFFER_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on the rising edge outside reset
`define KEBC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset
`define KEBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/kebc_pkg.sv]
// Types and constants shared by the keyboard event buffer controller modules
`default_nettype none

package kebc_pkg;

  localparam int unsigned KeyW = 8;
  localparam int unsigned RegW = 16;

  // Item commands
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_HOST    = 2'd2;

  // Host functions in register A
  localparam logic [RegW-1:0] FN_CLEAR   = 16'd0;
  localparam logic [RegW-1:0] FN_POP     = 16'd1;
  localparam logic [RegW-1:0] FN_TEST    = 16'd2;
  localparam logic [RegW-1:0] FN_SET_MSG = 16'd3;

  typedef struct packed {
    logic [1:0]      command;
    logic [KeyW-1:0] key_code;
    logic [RegW-1:0] reg_a;
    logic [RegW-1:0] reg_b;
  } kebc_in_t;

  typedef struct packed {
    logic [KeyW-1:0] reg_c_value;
    logic            reg_c_written;
    logic            irq_raise;
    logic [RegW-1:0] irq_message;
  } kebc_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } kebc_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } kebc_state_e;

endpackage

`default_nettype wire

[rtl/kebc_ctrl.sv]
// Controller state machine: item handshake, result register valid, commands
`default_nettype none

module kebc_ctrl import kebc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output kebc_cmd_t      cmd_o
);

  kebc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // commit only once the result register is free or being emptied
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result register holds until taken
  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/kebc_dp.sv]
// Datapath: typed-key buffer, held-key slots, message and result register
`default_nettype none

module kebc_dp import kebc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 8,
  parameter int unsigned HELD_SLOTS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire kebc_cmd_t cmd_i,
  input  wire kebc_in_t  in_item_i,
  output kebc_out_t      out_item_o
);

  localparam int unsigned PtrW  = $clog2(FIFO_DEPTH);
  localparam int unsigned CntW  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SlotW = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
  localparam logic [CntW-1:0] DepthCnt = CntW'(FIFO_DEPTH);
  localparam logic [CntW:0]   DepthSum = (CntW + 1)'(FIFO_DEPTH);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(FIFO_DEPTH - 1);

  kebc_in_t        item_q;
  logic [KeyW-1:0] rd_q;
  logic [KeyW-1:0] mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [KeyW-1:0] slots_q [HELD_SLOTS];
  logic [KeyW-1:0] slots_d [HELD_SLOTS];
  logic [RegW-1:0] msg_q, msg_d;
  kebc_out_t       out_q, out_d;

  logic            mem_we;
  logic [PtrW-1:0] mem_waddr;
  logic [CntW:0]   wr_sum;
  logic [PtrW-1:0] tail_ptr;
  logic            any_empty;
  logic [SlotW-1:0] first_empty;
  logic            held_hit;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  // Write position of the next typed key: head plus count, wrapped once
  assign wr_sum   = {1'b0, CntW'(head_q)} + {1'b0, count_q};
  assign tail_ptr = (wr_sum >= DepthSum) ? PtrW'(wr_sum - DepthSum) : PtrW'(wr_sum);

  // First empty held slot, lowest index wins
  always_comb begin
    any_empty   = 1'b0;
    first_empty = '0;
    for (int i = HELD_SLOTS - 1; i >= 0; i--) begin
      if (slots_q[i] == '0) begin
        any_empty   = 1'b1;
        first_empty = SlotW'(i);
      end
    end
  end

  // Held test compares the full operand width
  always_comb begin
    held_hit = 1'b0;
    for (int i = 0; i < HELD_SLOTS; i++) begin
      if ({{(RegW - KeyW){1'b0}}, slots_q[i]} == item_q.reg_b) begin
        held_hit = 1'b1;
      end
    end
  end

  // Item execution
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    slots_d   = slots_q;
    msg_d     = msg_q;
    out_d     = '0;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    unique case (item_q.command)
      CMD_PRESS: begin
        if (any_empty) begin
          slots_d[first_empty] = item_q.key_code;
        end else begin
          slots_d[0] = item_q.key_code;
        end
        mem_we = 1'b1;
        if (count_q < DepthCnt) begin
          mem_waddr = tail_ptr;
          count_d   = count_q + CntW'(1);
        end else begin
          // full: overwrite the oldest and move the head past it
          mem_waddr = head_q;
          head_d    = ptr_inc(head_q);
        end
        out_d.irq_raise   = (msg_q != '0);
        out_d.irq_message = msg_q;
      end
      CMD_RELEASE: begin
        for (int i = 0; i < HELD_SLOTS; i++) begin
          if (slots_q[i] == item_q.key_code) begin
            slots_d[i] = '0;
          end
        end
        out_d.irq_raise   = (msg_q != '0);
        out_d.irq_message = msg_q;
      end
      CMD_HOST: begin
        unique case (item_q.reg_a)
          FN_CLEAR: count_d = '0;
          FN_POP: begin
            out_d.reg_c_written = 1'b1;
            if (count_q != '0) begin
              out_d.reg_c_value = rd_q;
              head_d            = ptr_inc(head_q);
              count_d           = count_q - CntW'(1);
            end
          end
          FN_TEST: begin
            out_d.reg_c_written = 1'b1;
            out_d.reg_c_value   = {{(KeyW - 1){1'b0}}, held_hit};
          end
          FN_SET_MSG: msg_d = item_q.reg_b;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      msg_q   <= '0;
      for (int i = 0; i < HELD_SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      head_q  <= head_d;
      count_q <= count_d;
      msg_q   <= msg_d;
      slots_q <= slots_d;
    end
  end

  // Item capture with registered read of the oldest typed key
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
      rd_q   <= mem_q[head_q];
    end
  end

  // Typed-key buffer write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mem_we) begin
      mem_q[mem_waddr] <= item_q.key_code;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

[rtl/keyboard_event_buffer_controller_unit.sv]
// A result is registered at the commit of its item, which follows the accept
// in the EXEC state. Items are taken one at a time; the typed-key buffer is read
// through a registered port at accept and updated at the item's commit.
// A result waiting in the output register stalls the commit cycle only.
// Reset clears the held slots, key count, buffer head and message; the
// typed-key buffer contents are left as they are.
`default_nettype none

module keyboard_event_buffer_controller_unit import kebc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 8,
  parameter int unsigned HELD_SLOTS = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire kebc_in_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output kebc_out_t     out_item_o
);

`include "keyboard_event_buffer_controller_unit_assert.svh"

  kebc_cmd_t cmd;

  kebc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  kebc_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .HELD_SLOTS (HELD_SLOTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  // One item at a time: after an accept the input stalls for the commit cycle
  `KEBC_ASSERT_NEXT(a_accept_then_stall, clk_i, rst_ni, in_valid_i && !in_stall_o,
                    in_stall_o, "input accepted during commit cycle")
  // A commit never overwrites a result that is still waiting
  `KEBC_ASSERT_NOW(a_commit_free, clk_i, rst_ni, cmd.commit,
                   !out_valid_o || !out_stall_i, "result overwritten while stalled")
  // Every commit presents a result on the next cycle
  `KEBC_ASSERT_NEXT(a_commit_valid, clk_i, rst_ni, cmd.commit, out_valid_o,
                    "commit produced no result")

endmodule

`default_nettype wire
